[rtl/ipv4p_pkg.sv]
// Package for the dotted IPv4 address parser: parse state types, character
// codes, radix limits and the digit decode function. No dependencies.
package ipv4p_pkg;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_ZERO   = 4'b0010,
    PH_HEX0   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_t;

  typedef struct packed {
    phase_t      phase;
    radix_t      radix;
    logic [32:0] part_value;
    logic [2:0]  parts_done;
    logic [23:0] upper_bytes;
    logic        failed;
  } parse_state_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:       PH_START,
    radix:       RX_DEC,
    part_value:  33'd0,
    parts_done:  3'd0,
    upper_bytes: 24'd0,
    failed:      1'b0
  };

  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X_LOWER = 8'h78;

  localparam logic [4:0] NO_DIGIT = 5'd16;

  // Largest running value that may still take another digit, per radix
  localparam logic [32:0] LIM_DEC = 33'h0_1999_9999;
  localparam logic [32:0] LIM_OCT = 33'h0_1fff_ffff;
  localparam logic [32:0] LIM_HEX = 33'h0_0fff_ffff;

  localparam logic [32:0] BYTE_MAX = 33'h0_0000_00ff;

  // Digit value of a character, NO_DIGIT when it is none of 0-9, a-f, A-F
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h37);
    end
    return d;
  endfunction

endpackage

[rtl/ipv4p_if.sv]
// Valid/ready channel interfaces for the dotted IPv4 address parser:
// the character stream in and the parse result out. No dependencies.
interface ipv4p_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_mark;

  modport source (output valid, output ch, output end_mark, input ready);
  modport sink   (input valid, input ch, input end_mark, output ready);
endinterface

interface ipv4p_result_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] address;

  modport source (output valid, output valid_res, output address, input ready);
  modport sink   (input valid, input valid_res, input address, output ready);
endinterface

[rtl/ipv4p_step.sv]
// Next-state and end-of-text result logic for one character of the parser.
// Depends on ipv4p_pkg.
module ipv4p_step (
  input  ipv4p_pkg::parse_state_t  state,
  input  logic [7:0]               ch,
  output ipv4p_pkg::parse_state_t  state_next,
  output ipv4p_pkg::parse_result_t result
);
  import ipv4p_pkg::*;

  radix_t      radix_eff;
  logic [32:0] value_eff;
  logic [32:0] limit;
  logic [4:0]  base;
  logic [4:0]  digit;
  logic [36:0] scaled;
  logic [32:0] take_value;
  logic        take_ok;
  logic        close_ok;
  logic        is_dot;
  logic [32:0] end_limit;

  // A new part starts from zero in decimal
  always_comb begin
    if (state.phase == PH_START) begin
      radix_eff = RX_DEC;
      value_eff = '0;
    end else begin
      radix_eff = state.radix;
      value_eff = state.part_value;
    end
  end

  always_comb begin
    case (radix_eff)
      RX_OCT: begin
        base   = 5'd8;
        limit  = LIM_OCT;
        scaled = {value_eff, 3'b000} + 37'd0;
      end
      RX_HEX: begin
        base   = 5'd16;
        limit  = LIM_HEX;
        scaled = {value_eff, 4'b0000};
      end
      default: begin
        base   = 5'd10;
        limit  = LIM_DEC;
        scaled = {1'b0, value_eff, 3'b000} + {3'b000, value_eff, 1'b0};
      end
    endcase
  end

  assign digit      = digit_of(ch);
  assign take_ok    = (value_eff <= limit) && (digit < base);
  assign take_value = 33'(scaled + {32'd0, digit});
  assign close_ok   = state.part_value <= BYTE_MAX;
  assign is_dot     = ch == CH_DOT;

  always_comb begin
    state_next = state;
    if (!state.failed) begin
      unique case (state.phase) inside
        PH_START: begin
          if (state.parts_done >= 3'd4 || is_dot) begin
            state_next.failed = 1'b1;
          end else if (ch == CH_ZERO) begin
            state_next.part_value = '0;
            state_next.radix      = RX_OCT;
            state_next.phase      = PH_ZERO;
          end else if (take_ok) begin
            state_next.radix      = RX_DEC;
            state_next.part_value = take_value;
            state_next.phase      = PH_DIGITS;
          end else begin
            state_next.failed = 1'b1;
          end
        end
        PH_ZERO, PH_DIGITS: begin
          if (state.phase == PH_ZERO && ch == CH_X_LOWER) begin
            state_next.radix = RX_HEX;
            state_next.phase = PH_HEX0;
          end else if (is_dot) begin
            if (close_ok) begin
              state_next.upper_bytes = {state.upper_bytes[15:0], state.part_value[7:0]};
              state_next.parts_done  = state.parts_done + 3'd1;
              state_next.part_value  = '0;
              state_next.radix       = RX_DEC;
              state_next.phase       = PH_START;
            end else begin
              state_next.failed = 1'b1;
            end
          end else if (take_ok) begin
            state_next.part_value = take_value;
            state_next.phase      = PH_DIGITS;
          end else begin
            state_next.failed = 1'b1;
          end
        end
        PH_HEX0: begin
          // "0x" directly followed by a dot is an empty hex part
          if (!is_dot && take_ok) begin
            state_next.part_value = take_value;
            state_next.phase      = PH_DIGITS;
          end else begin
            state_next.failed = 1'b1;
          end
        end
        default: begin
          state_next.failed = 1'b1;
        end
      endcase
    end
  end

  // Last part fills the bytes the closed parts left over
  always_comb begin
    result.addr = '0;
    end_limit   = '0;
    case (state.parts_done)
      3'd0: begin
        end_limit   = 33'h0_ffff_ffff;
        result.addr = state.part_value[31:0];
      end
      3'd1: begin
        end_limit   = 33'h0_00ff_ffff;
        result.addr = {state.upper_bytes[7:0], state.part_value[23:0]};
      end
      3'd2: begin
        end_limit   = 33'h0_0000_ffff;
        result.addr = {state.upper_bytes[15:0], state.part_value[15:0]};
      end
      3'd3: begin
        end_limit   = 33'h0_0000_00ff;
        result.addr = {state.upper_bytes[23:0], state.part_value[7:0]};
      end
      default: begin
        end_limit   = '0;
        result.addr = '0;
      end
    endcase
    result.ok = !state.failed && state.phase != PH_START && state.parts_done <= 3'd3
                && state.part_value <= end_limit;
    if (!result.ok) begin
      result.addr = '0;
    end
  end

endmodule

[rtl/ipv4_dotted_address_parser_top.sv]
// Top level of the dotted IPv4 address parser (C-style dotted-quad rules).
// Depends on ipv4p_pkg, ipv4p_if and ipv4p_step.
//
// Feed the address text one character per transaction on text, then a
// transaction with end_mark set; that closes the text and yields one result
// transaction on result (valid_res and the 32-bit host-order address, zero
// when invalid) in the cycle after it is accepted, and the parser returns to
// its reset state. Any transaction can be accepted every cycle: the parse
// state is updated once per accepted character and the result sits in an
// output register, so text.ready drops only while a result is held and the
// result sink stalls. Characters produce no result.
module ipv4_dotted_address_parser_top (
  input logic            clk,
  input logic            rst,
  ipv4p_text_if.sink     text,
  ipv4p_result_if.source result
);
  import ipv4p_pkg::*;

  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t end_result;
  logic          out_valid;
  logic          out_valid_res;
  logic [31:0]   out_address;
  logic          accept;

  ipv4p_step u_step (
    .state      (state),
    .ch         (text.ch),
    .state_next (state_next),
    .result     (end_result)
  );

  assign text.ready       = !out_valid || result.ready;
  assign accept           = text.valid && text.ready;
  assign result.valid     = out_valid;
  assign result.valid_res = out_valid_res;
  assign result.address   = out_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= text.end_mark ? STATE_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && text.end_mark) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result register only on an end mark
  always_ff @(posedge clk) begin
    if (accept && text.end_mark) begin
      out_valid_res <= end_result.ok;
      out_address   <= end_result.addr;
    end
  end

endmodule

[rtl/ipv4p_checker.sv]
// Port-level assertions for the dotted IPv4 address parser, bound to the
// top level. Depends on ipv4_dotted_address_parser_top.
module ipv4p_checker (
  input logic        clk,
  input logic        rst,
  input logic        text_valid,
  input logic        text_ready,
  input logic        text_end_mark,
  input logic        result_valid,
  input logic        result_ready,
  input logic        result_valid_res,
  input logic [31:0] result_address
);

  // A stalled result must hold
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_address) && $stable(result_valid_res))
    else $error("result changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_valid_res |-> result_address == 32'd0)
    else $error("invalid result carries a nonzero address");

  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(text_valid && text_ready && text_end_mark))
    else $error("result appeared without an end mark");

  a_char_no_result: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_ready && !text_end_mark && !result_valid |=> !result_valid)
    else $error("character transaction produced a result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> text_ready)
    else $error("text stalled with empty result register");

endmodule

bind ipv4_dotted_address_parser_top ipv4p_checker u_ipv4p_checker (
  .clk              (clk),
  .rst              (rst),
  .text_valid       (text.valid),
  .text_ready       (text.ready),
  .text_end_mark    (text.end_mark),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_valid_res (result.valid_res),
  .result_address   (result.address)
);
